@@ sv/pftl_pkg.sv @@
package pftl_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_CLAMP = 2'd1;
  localparam status_t ST_DEGEN = 2'd2;

  localparam logic [31:0] Z_QUARTER = 32'h4000_0000;
  localparam logic [31:0] Z_MINUS_QUARTER = 32'hC000_0000;

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

@@ sv/pose_from_two_landmarks_top.sv @@
// Pose from two landmarks.
// Input: one word of eight coordinates (two observed landmarks in the robot
// frame, their two world positions) is taken at each clock edge where start
// is high and busy is low. busy stays low: a word may be taken every cycle.
// Output: out_valid is high for one cycle with pose x, pose y, heading and
// status of one word; results leave in the order the words came in.
// The pipeline runs through the bit-per-stage square root for the observed
// landmark distance, the restoring divider, the pair of offset square roots
// and the four-lane CORDIC, all fully pipelined.
// Throughput: one word per cycle.
// Reset: rst_n low clears all valid bits; words in flight are dropped.
// The receiver cannot stall; results are shown for exactly one cycle.
module pose_from_two_landmarks_top #(
  parameter int COORD_BITS   = 16,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_seen_left_x,
  input  logic signed [COORD_BITS-1:0]  in_seen_left_y,
  input  logic signed [COORD_BITS-1:0]  in_seen_right_x,
  input  logic signed [COORD_BITS-1:0]  in_seen_right_y,
  input  logic signed [COORD_BITS-1:0]  in_world_left_x,
  input  logic signed [COORD_BITS-1:0]  in_world_left_y,
  input  logic signed [COORD_BITS-1:0]  in_world_right_x,
  input  logic signed [COORD_BITS-1:0]  in_world_right_y,
  output logic                          out_valid,
  output logic signed [COORD_BITS-1:0]  out_pose_x,
  output logic signed [COORD_BITS-1:0]  out_pose_y,
  output logic signed [ANGLE_BITS-1:0]  out_heading,
  output pftl_pkg::status_t             out_status
);
  import pftl_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int S   = CORDIC_STEPS;
  localparam int SRW = 2*C + 18;
  localparam int NB  = C + 9;
  localparam int NW  = 2*C + 2;
  localparam int RW  = 2*C + 12;
  localparam int QB  = C + 3;
  localparam int PW  = C + 4;
  localparam int DW  = C + 5;
  localparam int RDW = 2*C + 11;
  localparam int OW  = 2*C + 2;
  localparam int OB  = C + 1;
  localparam int YW  = C + 3;
  localparam int CW  = C + 28;
  localparam int LAT = 15 + NB + QB + OB + S;

  localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
  localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};
  localparam logic [31:0] HRND = 32'd1 << (31 - ANGLE_BITS);

  typedef struct packed {
    logic                degen;
    logic signed [C-1:0] lx;
    logic signed [C-1:0] ly;
    logic signed [C-1:0] rx;
    logic signed [C-1:0] ry;
    logic signed [C-1:0] wlx;
    logic signed [C-1:0] wly;
    logic signed [C-1:0] wrx;
    logic signed [C-1:0] wry;
  } ctx_t;

  typedef struct packed {
    ctx_t          c;
    logic [NW-1:0] num;
    logic [2*C+1:0] sl;
    logic [2*C+1:0] sr;
  } a_t;

  typedef struct packed {
    ctx_t                 c;
    logic [2*C+1:0]       sl;
    logic [2*C+1:0]       sr;
    logic [QB-1:0]        line_d;
    logic signed [PW-1:0] px;
  } b_t;

  typedef struct packed {
    ctx_t                 c;
    logic                 clamp;
    logic signed [PW-1:0] px;
  } o_t;

  typedef struct packed {
    logic                 degen;
    logic                 clamp;
    logic signed [PW-1:0] px;
    logic signed [YW-1:0] py;
  } e_t;

  logic [LAT-1:0] vld_r;

  ctx_t               s1_c_r;
  logic signed [C:0]  s1_dx_r, s1_dy_r;
  ctx_t               s2_c_r;
  logic signed [2*C:0]   s2_p1_r, s2_p2_r, s2_lxx_r, s2_lyy_r, s2_rxx_r, s2_ryy_r;
  logic signed [2*C+1:0] s2_dxx_r, s2_dyy_r;
  logic signed [2*C+1:0] cross_nxt;
  logic [2*C+1:0]        sq_nxt;

  a_t             sn_a_r [NB+1];
  logic [SRW-1:0] sn_v_r [NB+1];
  logic [SRW-1:0] sn_q_r [NB+1];
  logic [NB-1:0]  n_root;

  a_t            dv_a_r   [QB+1];
  logic [NB-1:0] dv_n_r   [QB+1];
  logic [RW-1:0] dv_rem_r [QB+1];
  logic [QB-1:0] dv_q_r   [QB+1];

  b_t                     p1_b_r, p2_b_r, p3_b_r;
  logic signed [DW-1:0]   p2_dd_r;
  logic [2*QB-1:0]        p2_hl_r, p3_hl_r;
  logic signed [2*DW-1:0] p3_hr_r;
  logic signed [PW-1:0]   px_nxt;
  logic signed [RDW-1:0]  radl_nxt, radr_nxt;

  o_t            so_o_r [OB+1];
  logic [OW-1:0] so_v_r [OB+1][2];
  logic [OW-1:0] so_q_r [OB+1][2];

  o_t            r1_o_r;
  logic [OB-1:0] r1_off_r [2];

  logic signed [C:0]    wlye;
  logic [C:0]           wabs_nxt, wd_nxt;
  logic                 s1p_nxt, s2p_nxt;
  logic signed [YW-1:0] y1_nxt, y2_nxt;
  logic signed [YW:0]   ysum_nxt;
  e_t                   y_e_r;
  ctx_t                 y_c_r;

  e_t                   c0_e_r;
  logic signed [DW-1:0] c0_x_r [4];
  logic signed [DW-1:0] c0_y_r [4];

  e_t                   cr_e_r  [S+1];
  logic signed [CW-1:0] cr_x_r  [S+1][4];
  logic signed [CW-1:0] cr_y_r  [S+1][4];
  logic [31:0]          cr_z_r  [S+1][4];
  logic                 cr_zf_r [S+1][4];

  e_t          f1_e_r, f2_e_r;
  logic [31:0] f1_al_r, f1_ar_r, f2_h_r;
  logic [31:0] sd_nxt, hq_nxt;

  logic signed [C-1:0]          o_px_r, o_py_r;
  logic signed [ANGLE_BITS-1:0] o_hd_r;
  status_t                      o_st_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  // observed difference vector, products
  always_ff @(posedge clk) begin
    s1_c_r.degen <= (in_seen_left_x == in_seen_right_x) &&
                    (in_seen_left_y == in_seen_right_y);
    s1_c_r.lx  <= in_seen_left_x;
    s1_c_r.ly  <= in_seen_left_y;
    s1_c_r.rx  <= in_seen_right_x;
    s1_c_r.ry  <= in_seen_right_y;
    s1_c_r.wlx <= in_world_left_x;
    s1_c_r.wly <= in_world_left_y;
    s1_c_r.wrx <= in_world_right_x;
    s1_c_r.wry <= in_world_right_y;
    s1_dx_r <= $signed({in_seen_right_x[C-1], in_seen_right_x}) -
               $signed({in_seen_left_x[C-1], in_seen_left_x});
    s1_dy_r <= $signed({in_seen_right_y[C-1], in_seen_right_y}) -
               $signed({in_seen_left_y[C-1], in_seen_left_y});
  end

  always_ff @(posedge clk) begin
    s2_c_r   <= s1_c_r;
    s2_p1_r  <= (2*C+1)'($signed(s1_c_r.lx)) * (2*C+1)'(s1_dy_r);
    s2_p2_r  <= (2*C+1)'($signed(s1_c_r.ly)) * (2*C+1)'(s1_dx_r);
    s2_dxx_r <= (2*C+2)'(s1_dx_r) * (2*C+2)'(s1_dx_r);
    s2_dyy_r <= (2*C+2)'(s1_dy_r) * (2*C+2)'(s1_dy_r);
    s2_lxx_r <= (2*C+1)'($signed(s1_c_r.lx)) * (2*C+1)'($signed(s1_c_r.lx));
    s2_lyy_r <= (2*C+1)'($signed(s1_c_r.ly)) * (2*C+1)'($signed(s1_c_r.ly));
    s2_rxx_r <= (2*C+1)'($signed(s1_c_r.rx)) * (2*C+1)'($signed(s1_c_r.rx));
    s2_ryy_r <= (2*C+1)'($signed(s1_c_r.ry)) * (2*C+1)'($signed(s1_c_r.ry));
  end

  assign cross_nxt = (2*C+2)'(s2_p1_r) - (2*C+2)'(s2_p2_r);
  assign sq_nxt    = s2_dxx_r + s2_dyy_r;

  always_ff @(posedge clk) begin
    sn_a_r[0].c   <= s2_c_r;
    sn_a_r[0].num <= cross_nxt[2*C+1] ? -cross_nxt : cross_nxt;
    sn_a_r[0].sl  <= (2*C+2)'(s2_lxx_r) + (2*C+2)'(s2_lyy_r);
    sn_a_r[0].sr  <= (2*C+2)'(s2_rxx_r) + (2*C+2)'(s2_ryy_r);
    sn_v_r[0]     <= {sq_nxt, 16'd0};
    sn_q_r[0]     <= '0;
  end

  // |d| with 8 fraction bits, one root bit per stage
  for (genvar k = 0; k < NB; k++) begin : g_nsq
    localparam logic [SRW:0] BIT = {{SRW{1'b0}}, 1'b1} << (2*(NB-1-k));
    logic [SRW:0] trial;
    assign trial = {1'b0, sn_q_r[k]} + BIT;
    always_ff @(posedge clk) begin
      sn_a_r[k+1] <= sn_a_r[k];
      if ({1'b0, sn_v_r[k]} >= trial) begin
        sn_v_r[k+1] <= sn_v_r[k] - trial[SRW-1:0];
        sn_q_r[k+1] <= (sn_q_r[k] >> 1) + BIT[SRW-1:0];
      end else begin
        sn_v_r[k+1] <= sn_v_r[k];
        sn_q_r[k+1] <= sn_q_r[k] >> 1;
      end
    end
  end

  assign n_root = sn_q_r[NB][NB-1:0];

  always_ff @(posedge clk) begin
    dv_a_r[0]   <= sn_a_r[NB];
    dv_n_r[0]   <= n_root;
    dv_rem_r[0] <= {2'b00, sn_a_r[NB].num, 8'd0} +
                   {{(RW-NB+1){1'b0}}, n_root[NB-1:1]};
    dv_q_r[0]   <= '0;
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam logic [QB-1:0] QBIT = {{(QB-1){1'b0}}, 1'b1} << (QB-1-k);
    logic [RW-1:0] dsh;
    assign dsh = {{(RW-NB){1'b0}}, dv_n_r[k]} << (QB-1-k);
    always_ff @(posedge clk) begin
      dv_a_r[k+1] <= dv_a_r[k];
      dv_n_r[k+1] <= dv_n_r[k];
      if (dv_rem_r[k] >= dsh) begin
        dv_rem_r[k+1] <= dv_rem_r[k] - dsh;
        dv_q_r[k+1]   <= dv_q_r[k] | QBIT;
      end else begin
        dv_rem_r[k+1] <= dv_rem_r[k];
        dv_q_r[k+1]   <= dv_q_r[k];
      end
    end
  end

  always_comb begin
    if ($signed(dv_a_r[QB].c.wlx) > 0) begin
      px_nxt = PW'($signed(dv_a_r[QB].c.wlx)) - $signed({1'b0, dv_q_r[QB]});
    end else begin
      px_nxt = PW'($signed(dv_a_r[QB].c.wlx)) + $signed({1'b0, dv_q_r[QB]});
    end
  end

  always_ff @(posedge clk) begin
    p1_b_r.c      <= dv_a_r[QB].c;
    p1_b_r.sl     <= dv_a_r[QB].sl;
    p1_b_r.sr     <= dv_a_r[QB].sr;
    p1_b_r.line_d <= dv_q_r[QB];
    p1_b_r.px     <= px_nxt;
    p2_b_r        <= p1_b_r;
    p2_dd_r       <= DW'($signed(p1_b_r.c.wrx)) - DW'(p1_b_r.px);
    p2_hl_r       <= (2*QB)'(p1_b_r.line_d) * (2*QB)'(p1_b_r.line_d);
    p3_b_r        <= p2_b_r;
    p3_hl_r       <= p2_hl_r;
    p3_hr_r       <= (2*DW)'(p2_dd_r) * (2*DW)'(p2_dd_r);
  end

  assign radl_nxt = $signed({{(RDW-2*C-2){1'b0}}, p3_b_r.sl}) -
                    $signed({{(RDW-2*QB){1'b0}}, p3_hl_r});
  assign radr_nxt = $signed({{(RDW-2*C-2){1'b0}}, p3_b_r.sr}) - RDW'(p3_hr_r);

  always_ff @(posedge clk) begin
    so_o_r[0].c     <= p3_b_r.c;
    so_o_r[0].px    <= p3_b_r.px;
    so_o_r[0].clamp <= radl_nxt[RDW-1] || radr_nxt[RDW-1];
    so_v_r[0][0]    <= radl_nxt[RDW-1] ? '0 : radl_nxt[OW-1:0];
    so_v_r[0][1]    <= radr_nxt[RDW-1] ? '0 : radr_nxt[OW-1:0];
    so_q_r[0][0]    <= '0;
    so_q_r[0][1]    <= '0;
  end

  // left and right offsets
  for (genvar k = 0; k < OB; k++) begin : g_osq
    localparam logic [OW:0] BIT = {{OW{1'b0}}, 1'b1} << (2*(OB-1-k));
    always_ff @(posedge clk) begin
      so_o_r[k+1] <= so_o_r[k];
    end
    for (genvar j = 0; j < 2; j++) begin : g_side
      logic [OW:0] trial;
      assign trial = {1'b0, so_q_r[k][j]} + BIT;
      always_ff @(posedge clk) begin
        if ({1'b0, so_v_r[k][j]} >= trial) begin
          so_v_r[k+1][j] <= so_v_r[k][j] - trial[OW-1:0];
          so_q_r[k+1][j] <= (so_q_r[k][j] >> 1) + BIT[OW-1:0];
        end else begin
          so_v_r[k+1][j] <= so_v_r[k][j];
          so_q_r[k+1][j] <= so_q_r[k][j] >> 1;
        end
      end
    end
  end

  // round to nearest: remainder above root bumps the root
  always_ff @(posedge clk) begin
    r1_o_r <= so_o_r[OB];
    for (int j = 0; j < 2; j++) begin
      r1_off_r[j] <= so_q_r[OB][j][OB-1:0] + OB'(so_v_r[OB][j] > so_q_r[OB][j]);
    end
  end

  // case choice on offsets, then average
  assign wlye = (C+1)'($signed(r1_o_r.c.wly));

  always_comb begin
    wabs_nxt = wlye[C] ? -wlye : wlye;
    wd_nxt   = {wabs_nxt[C-1:0], 1'b0};
    if ((r1_off_r[0] < wd_nxt) && (r1_off_r[1] < wd_nxt)) begin
      s1p_nxt = wlye[C];
      s2p_nxt = !wlye[C];
    end else if (r1_off_r[0] > r1_off_r[1]) begin
      s1p_nxt = wlye[C];
      s2p_nxt = wlye[C];
    end else begin
      s1p_nxt = !wlye[C];
      s2p_nxt = !wlye[C];
    end
    y1_nxt = s1p_nxt ? YW'($signed(r1_o_r.c.wly)) + $signed({2'b00, r1_off_r[0]})
                     : YW'($signed(r1_o_r.c.wly)) - $signed({2'b00, r1_off_r[0]});
    y2_nxt = s2p_nxt ? YW'($signed(r1_o_r.c.wry)) + $signed({2'b00, r1_off_r[1]})
                     : YW'($signed(r1_o_r.c.wry)) - $signed({2'b00, r1_off_r[1]});
    ysum_nxt = (YW+1)'(y1_nxt) + (YW+1)'(y2_nxt);
  end

  always_ff @(posedge clk) begin
    y_c_r       <= r1_o_r.c;
    y_e_r.degen <= r1_o_r.c.degen;
    y_e_r.clamp <= r1_o_r.clamp;
    y_e_r.px    <= r1_o_r.px;
    y_e_r.py    <= ysum_nxt[YW:1];
  end

  // bearing vectors: world-left, seen-left, world-right, seen-right
  always_ff @(posedge clk) begin
    c0_e_r    <= y_e_r;
    c0_x_r[0] <= DW'($signed(y_c_r.wlx)) - DW'(y_e_r.px);
    c0_y_r[0] <= DW'($signed(y_c_r.wly)) - DW'(y_e_r.py);
    c0_x_r[1] <= DW'($signed(y_c_r.lx));
    c0_y_r[1] <= DW'($signed(y_c_r.ly));
    c0_x_r[2] <= DW'($signed(y_c_r.wrx)) - DW'(y_e_r.px);
    c0_y_r[2] <= DW'($signed(y_c_r.wry)) - DW'(y_e_r.py);
    c0_x_r[3] <= DW'($signed(y_c_r.rx));
    c0_y_r[3] <= DW'($signed(y_c_r.ry));
  end

  always_ff @(posedge clk) begin
    cr_e_r[0] <= c0_e_r;
  end

  // quarter-turn pre-rotation into the right half plane, scale by 2^20
  for (genvar j = 0; j < 4; j++) begin : g_pre
    logic signed [DW:0] xw, yw, xp, yp;
    logic [31:0]        zp;
    assign xw = (DW+1)'(c0_x_r[j]);
    assign yw = (DW+1)'(c0_y_r[j]);
    always_comb begin
      if (!xw[DW]) begin
        xp = xw;
        yp = yw;
        zp = '0;
      end else if (!yw[DW]) begin
        xp = yw;
        yp = -xw;
        zp = Z_QUARTER;
      end else begin
        xp = -yw;
        yp = xw;
        zp = Z_MINUS_QUARTER;
      end
    end
    always_ff @(posedge clk) begin
      cr_x_r[0][j]  <= CW'(xp) <<< 20;
      cr_y_r[0][j]  <= CW'(yp) <<< 20;
      cr_z_r[0][j]  <= zp;
      cr_zf_r[0][j] <= (xw == '0) && (yw == '0);
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      cr_e_r[i+1] <= cr_e_r[i];
    end
    for (genvar j = 0; j < 4; j++) begin : g_lane
      always_ff @(posedge clk) begin
        cr_zf_r[i+1][j] <= cr_zf_r[i][j];
        if (!cr_y_r[i][j][CW-1]) begin
          cr_x_r[i+1][j] <= cr_x_r[i][j] + (cr_y_r[i][j] >>> i);
          cr_y_r[i+1][j] <= cr_y_r[i][j] - (cr_x_r[i][j] >>> i);
          cr_z_r[i+1][j] <= cr_z_r[i][j] + ATAN_TAB[i];
        end else begin
          cr_x_r[i+1][j] <= cr_x_r[i][j] - (cr_y_r[i][j] >>> i);
          cr_y_r[i+1][j] <= cr_y_r[i][j] + (cr_x_r[i][j] >>> i);
          cr_z_r[i+1][j] <= cr_z_r[i][j] - ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    f1_e_r  <= cr_e_r[S];
    f1_al_r <= (cr_zf_r[S][0] ? 32'd0 : cr_z_r[S][0]) -
               (cr_zf_r[S][1] ? 32'd0 : cr_z_r[S][1]);
    f1_ar_r <= (cr_zf_r[S][2] ? 32'd0 : cr_z_r[S][2]) -
               (cr_zf_r[S][3] ? 32'd0 : cr_z_r[S][3]);
  end

  // circular mean: left angle plus half the wrapped difference
  assign sd_nxt = f1_ar_r - f1_al_r;

  always_ff @(posedge clk) begin
    f2_e_r <= f1_e_r;
    f2_h_r <= f1_al_r + {sd_nxt[31], sd_nxt[31:1]};
  end

  assign hq_nxt = f2_h_r + HRND;

  always_ff @(posedge clk) begin
    if (f2_e_r.degen) begin
      o_px_r <= '0;
      o_py_r <= '0;
      o_hd_r <= '0;
      o_st_r <= ST_DEGEN;
    end else begin
      if (f2_e_r.px > CMAX) begin
        o_px_r <= CMAX;
      end else if (f2_e_r.px < CMIN) begin
        o_px_r <= CMIN;
      end else begin
        o_px_r <= f2_e_r.px[C-1:0];
      end
      if (f2_e_r.py > CMAX) begin
        o_py_r <= CMAX;
      end else if (f2_e_r.py < CMIN) begin
        o_py_r <= CMIN;
      end else begin
        o_py_r <= f2_e_r.py[C-1:0];
      end
      o_hd_r <= hq_nxt[31 -: ANGLE_BITS];
      o_st_r <= f2_e_r.clamp ? ST_CLAMP : ST_OK;
    end
  end

  assign out_valid   = vld_r[LAT-1];
  assign out_pose_x  = o_px_r;
  assign out_pose_y  = o_py_r;
  assign out_heading = o_hd_r;
  assign out_status  = o_st_r;

endmodule

@@ sim/tb_pose_from_two_landmarks_top.sv @@
module tb_pose_from_two_landmarks_top;
  import pftl_pkg::*;

  typedef struct packed {
    logic signed [15:0] slx, sly, srx, sry, wlx, wly, wrx, wry;
  } landmark_word_t;

  typedef struct packed {
    logic signed [15:0] px, py, hd;
    status_t st;
  } pose_t;

  typedef struct packed {
    landmark_word_t w;
    bit typed;
    pose_t p;
  } row_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid;
  logic signed [15:0] in_seen_left_x = 0, in_seen_left_y = 0;
  logic signed [15:0] in_seen_right_x = 0, in_seen_right_y = 0;
  logic signed [15:0] in_world_left_x = 0, in_world_left_y = 0;
  logic signed [15:0] in_world_right_x = 0, in_world_right_y = 0;
  logic signed [15:0] out_pose_x, out_pose_y, out_heading;
  status_t out_status;

  pose_t pending_poses[$];
  int errors = 0;
  int idle_cycles = 0;
  bit took_word = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  pose_from_two_landmarks_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_seen_left_x(in_seen_left_x), .in_seen_left_y(in_seen_left_y),
    .in_seen_right_x(in_seen_right_x), .in_seen_right_y(in_seen_right_y),
    .in_world_left_x(in_world_left_x), .in_world_left_y(in_world_left_y),
    .in_world_right_x(in_world_right_x), .in_world_right_y(in_world_right_y),
    .out_valid(out_valid), .out_pose_x(out_pose_x), .out_pose_y(out_pose_y),
    .out_heading(out_heading), .out_status(out_status)
  );

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint offset_sqrt(longint v, inout bit clamped);
    longint unsigned q;
    if (v < 0) begin
      clamped = 1;
      return 0;
    end
    q = isqrt(v);
    if (longint'(v) - longint'(q * q) > longint'(q)) q++;
    return longint'(q);
  endfunction

  function automatic logic [31:0] bearing_of(longint x, longint y);
    logic [31:0] z;
    longint t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = Z_QUARTER;
      end else begin
        t = x; x = -y; y = t; z = Z_MINUS_QUARTER;
      end
    end
    x = x * 1048576;
    y = y * 1048576;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic pose_t solve_pose(landmark_word_t w);
    pose_t p;
    longint lx, ly, rx, ry, wlx, wly, wrx, wry, dx, dy, cr, line_d, px, py;
    longint offl, offr, width, y1, y2, sd;
    longint unsigned n, num;
    logic [31:0] al, ar, diff, h;
    bit clamped;
    lx = w.slx; ly = w.sly; rx = w.srx; ry = w.sry;
    wlx = w.wlx; wly = w.wly; wrx = w.wrx; wry = w.wry;
    dx = rx - lx; dy = ry - ly;
    clamped = 0;
    if (dx == 0 && dy == 0) begin
      p.px = 0; p.py = 0; p.hd = 0; p.st = ST_DEGEN;
      return p;
    end
    cr = lx * dy - ly * dx;
    num = cr < 0 ? -cr : cr;
    n = isqrt(longint'(dx * dx + dy * dy) << 16);
    line_d = longint'(((num << 8) + (n >> 1)) / n);
    px = wlx > 0 ? wlx - line_d : wlx + line_d;
    offl = offset_sqrt(lx * lx + ly * ly - (wlx - px) * (wlx - px), clamped);
    offr = offset_sqrt(rx * rx + ry * ry - (wrx - px) * (wrx - px), clamped);
    width = (wly < 0 ? -wly : wly) * 2;
    if (offl < width && offr < width) begin
      if (wly < 0) begin y1 = wly + offl; y2 = wry - offr; end
      else begin y1 = wly - offl; y2 = wry + offr; end
    end else if (offl > offr) begin
      if (wly < 0) begin y1 = wly + offl; y2 = wry + offr; end
      else begin y1 = wly - offl; y2 = wry - offr; end
    end else begin
      if (wly < 0) begin y1 = wly - offl; y2 = wry - offr; end
      else begin y1 = wly + offl; y2 = wry + offr; end
    end
    py = (y1 + y2) >>> 1;
    al = bearing_of(wlx - px, wly - py) - bearing_of(lx, ly);
    ar = bearing_of(wrx - px, wry - py) - bearing_of(rx, ry);
    diff = ar - al;
    sd = longint'(signed'(diff));
    h = al + 32'(sd >>> 1);
    h = h + 32'h0000_8000;
    p.px = sat16(px);
    p.py = sat16(py);
    p.hd = h[31:16];
    p.st = clamped ? ST_CLAMP : ST_OK;
    return p;
  endfunction

  // landmarks placed in the world, observed from a random robot pose
  function automatic landmark_word_t scene_word();
    landmark_word_t w;
    real th, c, s, rpx, rpy, ex, ey;
    w.wlx = $urandom_range(0, 12000) - 6000;
    w.wly = $urandom_range(0, 8000) - 4000;
    w.wrx = $urandom_range(0, 12000) - 6000;
    w.wry = $urandom_range(0, 8000) - 4000;
    rpx = real'($urandom_range(0, 9000)) - 4500.0;
    rpy = real'($urandom_range(0, 6000)) - 3000.0;
    th = (real'($urandom_range(0, 62831)) / 10000.0) - 3.14159;
    c = $cos(th);
    s = $sin(th);
    ex = w.wlx - rpx; ey = w.wly - rpy;
    w.slx = $rtoi(c * ex + s * ey);
    w.sly = $rtoi(c * ey - s * ex);
    ex = w.wrx - rpx; ey = w.wry - rpy;
    w.srx = $rtoi(c * ex + s * ey);
    w.sry = $rtoi(c * ey - s * ex);
    if ($urandom_range(0, 4) == 0) begin
      w.slx += $urandom_range(0, 200) - 100;
      w.sry += $urandom_range(0, 200) - 100;
    end
    return w;
  endfunction

  task automatic send_word(landmark_word_t w, bit typed, pose_t p);
    start <= 1;
    in_seen_left_x <= w.slx; in_seen_left_y <= w.sly;
    in_seen_right_x <= w.srx; in_seen_right_y <= w.sry;
    in_world_left_x <= w.wlx; in_world_left_y <= w.wly;
    in_world_right_x <= w.wrx; in_world_right_y <= w.wry;
    do @(posedge clk); while (busy);
    took_word = 1;
    pending_poses.push_back(typed ? p : solve_pose(w));
  endtask

  task automatic idle_gap(bit quiet);
    int g;
    if (quiet) return;
    g = $urandom_range(0, 9);
    if (g < 6) return;
    start <= 0;
    repeat (g < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      took_word = 1;
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d h=%0d st=%0d", $time,
                 out_pose_x, out_pose_y, out_heading, out_status);
        errors++;
      end else begin
        pose_t e;
        e = pending_poses.pop_front();
        if (e.px !== out_pose_x) begin
          $display("%0t: pose_x exp %0d got %0d", $time, e.px, out_pose_x); errors++;
        end
        if (e.py !== out_pose_y) begin
          $display("%0t: pose_y exp %0d got %0d", $time, e.py, out_pose_y); errors++;
        end
        if (e.hd !== out_heading) begin
          $display("%0t: heading exp %0d got %0d", $time, e.hd, out_heading); errors++;
        end
        if (e.st !== out_status) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, out_status); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    idle_cycles = took_word ? 0 : idle_cycles + 1;
    took_word = 0;
    if (idle_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  localparam pose_t DEGEN = '{px: 0, py: 0, hd: 0, st: ST_DEGEN};
  localparam pose_t NONE = '0;

  row_t directed[] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, DEGEN},
    '{'{32767, 32767, 32767, 32767, -32768, 32767, -32768, 32767}, 1, DEGEN},
    '{'{-32768, -32768, -32768, -32768, 32767, -32768, 32767, -32768}, 1, DEGEN},
    '{'{-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768}, 0, NONE},
    '{'{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}, 0, NONE},
    '{'{1000, 500, 1000, -500, 3000, 500, 3000, -500}, 0, NONE},
    '{'{1000, 500, 1000, -500, 3000, -500, 3000, 500}, 0, NONE},
    '{'{1000, 500, 1000, -500, 3000, 0, 3000, -1000}, 0, NONE},
    '{'{10, 0, 10, 5, 30000, 2000, -30000, -2000}, 0, NONE},
    '{'{0, 0, 2000, 0, 1000, 1000, 3000, 1000}, 0, NONE},
    '{'{-1500, 0, 1500, 0, -1500, 0, 1500, 0}, 0, NONE},
    '{'{1500, 0, -1500, 0, 0, 1500, 0, -1500}, 0, NONE},
    '{'{-2000, 3000, -2000, -3000, -4500, 1100, -4500, -1100}, 0, NONE},
    '{'{2000, 100, 2100, -100, 4500, -300, 4500, 300}, 0, NONE},
    '{'{-1, -1, 1, 1, 1, -1, -1, 1}, 0, NONE}
  };

  initial begin
    int quiet;
    landmark_word_t w;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_word(directed[i].w, directed[i].typed, directed[i].p);
      idle_gap(0);
    end
    quiet = 0;
    for (int k = 0; k < 700; k++) begin
      if (quiet > 0) quiet--;
      else if ($urandom_range(0, 49) == 0) quiet = $urandom_range(20, 60);
      case ($urandom_range(0, 9))
        0, 1: w = landmark_word_t'({$urandom, $urandom, $urandom, $urandom});
        2: begin
          w = scene_word();
          w.srx = w.slx;
          w.sry = w.sly;
        end
        default: w = scene_word();
      endcase
      send_word(w, 0, NONE);
      idle_gap(quiet > 0);
    end
    start <= 0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
